@@ rtl/tvol_pkg.sv @@
// ----------------------------------------------------------------------------
// tvol_pkg
// Shared types, widths and term tables for the tetrahedron volume unit.
// ----------------------------------------------------------------------------
package tvol_pkg;

    localparam int EDGE_W  = 16;
    localparam int SQ_W    = 32;
    localparam int PAIR_W  = 64;
    localparam int TERM_W  = 96;
    localparam int SUM_W   = 104;
    localparam int REM_W   = 104;
    localparam int DEL_W   = 106;
    localparam int ROOT_W  = 48;
    localparam int BIT_W   = 6;
    localparam int N_EDGE  = 6;
    localparam int N_TERM  = 22;
    localparam int N_PAD   = 32;
    localparam int N_STAGE = 9;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_12;
        logic [EDGE_W-1:0] edge_13;
        logic [EDGE_W-1:0] edge_14;
        logic [EDGE_W-1:0] edge_23;
        logic [EDGE_W-1:0] edge_24;
        logic [EDGE_W-1:0] edge_34;
    } t_in;

    typedef struct packed {
        logic [ROOT_W-1:0] volume;
        logic              degenerate;
    } t_out;

    // one slot of the root chain
    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              degen;
    } t_root;

    typedef logic [2:0] t_idx;

    // squared edge indices: 0=12 1=13 2=14 3=23 4=24 5=34
    localparam t_idx TERM_A [N_TERM] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd1, 3'd3,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd0, 3'd2, 3'd0, 3'd1};
    localparam t_idx TERM_B [N_TERM] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd2, 3'd4,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4};
    localparam t_idx TERM_C [N_TERM] = '{
        3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd5, 3'd5,
        3'd4, 3'd5, 3'd3, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5};
    localparam logic TERM_NEG [N_TERM] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

endpackage

@@ rtl/tvol_poly.sv @@
// ----------------------------------------------------------------------------
// tvol_poly
// Pipelined Cayley-Menger polynomial: squares, triple products, adder tree.
// ----------------------------------------------------------------------------
module tvol_poly
    import tvol_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_adv,
    input  t_in                     i_data,
    output logic                    o_valid,
    input  logic                    i_adv,
    output logic signed [SUM_W-1:0] o_sum
);

    logic [N_STAGE:1]   r_v;
    logic [N_STAGE+1:1] adv;

    logic [SQ_W-1:0]   r_e  [N_EDGE];
    logic [PAIR_W-1:0] r_ab [N_TERM];
    logic [SQ_W-1:0]   r_c  [N_TERM];
    logic [PAIR_W-1:0] r_ph [N_TERM];
    logic [PAIR_W-1:0] r_pl [N_TERM];
    logic signed [SUM_W-1:0] r_t  [N_TERM];
    logic signed [SUM_W-1:0] r_l1 [16];
    logic signed [SUM_W-1:0] r_l2 [8];
    logic signed [SUM_W-1:0] r_l3 [4];
    logic signed [SUM_W-1:0] r_l4 [2];
    logic signed [SUM_W-1:0] r_l5;

    logic [EDGE_W-1:0]       edges [N_EDGE];
    logic signed [SUM_W-1:0] pad   [N_PAD];
    logic [TERM_W-1:0]       mag   [N_TERM];

    // stage moves when empty or when the next one moves
    always_comb begin
        adv[N_STAGE+1] = i_adv;
        for (int k = N_STAGE; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_adv   = adv[1];
    assign o_valid = r_v[N_STAGE];
    assign o_sum   = r_l5;

    always_comb begin
        edges[0] = i_data.edge_12;
        edges[1] = i_data.edge_13;
        edges[2] = i_data.edge_14;
        edges[3] = i_data.edge_23;
        edges[4] = i_data.edge_24;
        edges[5] = i_data.edge_34;
    end

    // full triple product magnitude from the two partial products
    always_comb begin
        for (int t = 0; t < N_TERM; t++) begin
            mag[t] = (TERM_W'(r_ph[t]) << 32) + TERM_W'(r_pl[t]);
        end
    end

    // zero-pad the terms to a power of two for the tree
    always_comb begin
        for (int t = 0; t < N_PAD; t++) begin
            pad[t] = '0;
        end
        for (int t = 0; t < N_TERM; t++) begin
            pad[t] = r_t[t];
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= N_STAGE; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int i = 0; i < N_EDGE; i++) begin
                r_e[i] <= SQ_W'(edges[i]) * SQ_W'(edges[i]);
            end
        end
        if (adv[2]) begin
            for (int t = 0; t < N_TERM; t++) begin
                r_ab[t] <= PAIR_W'(r_e[TERM_A[t]]) * PAIR_W'(r_e[TERM_B[t]]);
                r_c[t]  <= r_e[TERM_C[t]];
            end
        end
        if (adv[3]) begin
            for (int t = 0; t < N_TERM; t++) begin
                r_ph[t] <= PAIR_W'(r_ab[t][63:32]) * PAIR_W'(r_c[t]);
                r_pl[t] <= PAIR_W'(r_ab[t][31:0]) * PAIR_W'(r_c[t]);
            end
        end
        if (adv[4]) begin
            for (int t = 0; t < N_TERM; t++) begin
                r_t[t] <= TERM_NEG[t] ? -$signed(SUM_W'(mag[t])) : $signed(SUM_W'(mag[t]));
            end
        end
        if (adv[5]) begin
            for (int j = 0; j < 16; j++) begin
                r_l1[j] <= pad[2*j] + pad[2*j+1];
            end
        end
        if (adv[6]) begin
            for (int j = 0; j < 8; j++) begin
                r_l2[j] <= r_l1[2*j] + r_l1[2*j+1];
            end
        end
        if (adv[7]) begin
            for (int j = 0; j < 4; j++) begin
                r_l3[j] <= r_l2[2*j] + r_l2[2*j+1];
            end
        end
        if (adv[8]) begin
            for (int j = 0; j < 2; j++) begin
                r_l4[j] <= r_l3[2*j] + r_l3[2*j+1];
            end
        end
        if (adv[9]) begin
            r_l5 <= r_l4[0] + r_l4[1];
        end
    end

endmodule

@@ rtl/tvol_root_cell.sv @@
// ----------------------------------------------------------------------------
// tvol_root_cell
// One bit of the scaled square root: keep the bit if 144*r^2 still fits.
// ----------------------------------------------------------------------------
module tvol_root_cell
    import tvol_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BIT_W-1:0] i_bit,
    input  t_root            i_slot,
    output logic             o_adv,
    output t_root            o_slot,
    input  logic             i_adv
);

    t_root            r_slot;
    t_root            n_slot;
    logic [DEL_W-1:0] x;
    logic [DEL_W-1:0] delta;
    logic [DEL_W-1:0] rem_ext;
    logic             take;

    assign o_adv  = !r_slot.valid || i_adv;
    assign o_slot = r_slot;

    // delta = 144 * ((r + 2^b)^2 - r^2)
    always_comb begin
        x       = (DEL_W'({i_slot.root, 1'b0}) | (DEL_W'(1) << i_bit)) << i_bit;
        delta   = (x << 7) + (x << 4);
        rem_ext = DEL_W'(i_slot.rem);
        take    = (delta <= rem_ext);
        n_slot  = i_slot;
        if (take) begin
            n_slot.rem  = REM_W'(rem_ext - delta);
            n_slot.root = i_slot.root | (ROOT_W'(1) << i_bit);
        end
    end

    // hold valid under reset, advance with the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (o_adv) begin
            r_slot.valid <= i_slot.valid;
        end
        if (o_adv) begin
            r_slot.rem   <= n_slot.rem;
            r_slot.root  <= n_slot.root;
            r_slot.degen <= n_slot.degen;
        end
    end

endmodule

@@ rtl/tetrahedron_volume_from_edges_unit.sv @@
// ----------------------------------------------------------------------------
// tetrahedron_volume_from_edges_unit
// Tetrahedron volume (Q24.24) from six Q8.8 edge lengths via Cayley-Menger.
// ----------------------------------------------------------------------------
// Fully pipelined: one request accepted per cycle while o_ready is high
// (squares, split 32x32 triple products and a five-level adder tree, then
// a chain of 48 root cells, one result bit each). Stages fill bubbles
// independently, so requests keep entering while a result waits, until full.
// Negative polynomials give volume zero with degenerate set.
module tetrahedron_volume_from_edges_unit
    import tvol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic                    poly_valid;
    logic signed [SUM_W-1:0] poly_sum;
    t_root                   slot [ROOT_W+1];
    logic                    adv  [ROOT_W+1];

    tvol_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_adv   (o_ready),
        .i_data  (i_data),
        .o_valid (poly_valid),
        .i_adv   (adv[0]),
        .o_sum   (poly_sum)
    );

    // drop negative polynomials to zero and flag them
    always_comb begin
        slot[0].valid = poly_valid;
        slot[0].degen = poly_sum[SUM_W-1];
        slot[0].rem   = poly_sum[SUM_W-1] ? '0 : REM_W'(poly_sum);
        slot[0].root  = '0;
    end

    // root chain, most significant bit first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        tvol_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (BIT_W'(ROOT_W - 1 - k)),
            .i_slot  (slot[k]),
            .o_adv   (adv[k]),
            .o_slot  (slot[k+1]),
            .i_adv   (adv[k+1])
        );
    end

    assign adv[ROOT_W]       = i_ready;
    assign o_valid           = slot[ROOT_W].valid;
    assign o_data.volume     = slot[ROOT_W].root;
    assign o_data.degenerate = slot[ROOT_W].degen;

endmodule

@@ rtl/tvol_checker.sv @@
// ----------------------------------------------------------------------------
// tvol_checker
// Port-level checks for the tetrahedron volume unit.
// ----------------------------------------------------------------------------
module tvol_checker
    import tvol_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // flagged requests carry zero volume
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.volume == '0)
        else $error("degenerate result with nonzero volume");

    // volume stays below 2^47 for Q8.8 edges
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_data.volume[ROOT_W-1])
        else $error("volume out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind tetrahedron_volume_from_edges_unit tvol_checker u_chk (.*);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tetrahedron volume unit: directed edge sets,
// then random near-regular and free-form tetrahedra under random source
// bursts and sink stalls, each result checked in order against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tvol_pkg::*;

    localparam int N_RANDOM  = 550;
    localparam int LATENCY   = 57;
    localparam int MAX_CYCLE = 400000;

    // Predict volumes and hold them in request order
    class volume_board;
        t_out vol_q[$];
        int   n_err;

        function new();
            n_err = 0;
        endfunction

        function t_out predict_volume(t_in x);
            logic [127:0] sq [N_EDGE];
            logic [127:0] pos, neg, diff, quo, root, cand;
            t_out r;
            sq[0] = x.edge_12 * x.edge_12;
            sq[1] = x.edge_13 * x.edge_13;
            sq[2] = x.edge_14 * x.edge_14;
            sq[3] = x.edge_23 * x.edge_23;
            sq[4] = x.edge_24 * x.edge_24;
            sq[5] = x.edge_34 * x.edge_34;
            neg = sq[0]*sq[0]*sq[5] + sq[1]*sq[1]*sq[4] + sq[2]*sq[2]*sq[3]
                + sq[3]*sq[3]*sq[2] + sq[4]*sq[4]*sq[1] + sq[5]*sq[5]*sq[0]
                + sq[0]*sq[1]*sq[3] + sq[0]*sq[2]*sq[4] + sq[1]*sq[2]*sq[5]
                + sq[3]*sq[4]*sq[5];
            pos = sq[0]*sq[1]*sq[4] + sq[0]*sq[1]*sq[5] + sq[0]*sq[2]*sq[3]
                + sq[0]*sq[2]*sq[5] + sq[1]*sq[2]*sq[3] + sq[1]*sq[2]*sq[4]
                + sq[1]*sq[3]*sq[4] + sq[2]*sq[3]*sq[4] + sq[0]*sq[3]*sq[5]
                + sq[2]*sq[3]*sq[5] + sq[0]*sq[4]*sq[5] + sq[1]*sq[4]*sq[5];
            if (pos < neg) begin
                r.volume     = '0;
                r.degenerate = 1'b1;
            end else begin
                diff = pos - neg;
                quo  = diff / 128'd144;
                root = '0;
                // build the truncated root one bit at a time
                for (int b = 63; b >= 0; b--) begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= quo) root = cand;
                end
                r.volume     = root[ROOT_W-1:0];
                r.degenerate = 1'b0;
            end
            return r;
        endfunction

        function void note_request(t_in x);
            vol_q.push_back(predict_volume(x));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (vol_q.size() == 0) begin
                $error("unexpected result volume=%0h degenerate=%0b",
                       got.volume, got.degenerate);
                n_err++;
                return;
            end
            want = vol_q.pop_front();
            if (got.volume !== want.volume) begin
                $error("volume: expected %0h actual %0h", want.volume, got.volume);
                n_err++;
            end
            if (got.degenerate !== want.degenerate) begin
                $error("degenerate: expected %0b actual %0b",
                       want.degenerate, got.degenerate);
                n_err++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    t_in  i_data;
    t_out o_data;
    volume_board board;
    int   cycle;

    tetrahedron_volume_from_edges_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_result(o_data);
    end

    // Offer one request and hold it until accepted
    task automatic send_request(t_in x);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= x;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(x);
    endtask

    task automatic send_edges(int a, int b, int c, int d, int e, int f);
        t_in x;
        x.edge_12 = EDGE_W'(a); x.edge_13 = EDGE_W'(b); x.edge_14 = EDGE_W'(c);
        x.edge_23 = EDGE_W'(d); x.edge_24 = EDGE_W'(e); x.edge_34 = EDGE_W'(f);
        send_request(x);
    endtask

    function automatic logic [15:0] near_edge(int base, int spread);
        int v;
        v = base + $urandom_range(2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    // Random request: mostly near-regular tetrahedra, some free-form noise
    function automatic t_in random_request();
        t_in x;
        int  base, spread;
        if ($urandom_range(9) < 7) begin
            base   = $urandom_range(65535);
            spread = base / ($urandom_range(6) + 2);
            x.edge_12 = near_edge(base, spread);
            x.edge_13 = near_edge(base, spread);
            x.edge_14 = near_edge(base, spread);
            x.edge_23 = near_edge(base, spread);
            x.edge_24 = near_edge(base, spread);
            x.edge_34 = near_edge(base, spread);
        end else begin
            x = {$urandom, $urandom, $urandom};
        end
        return x;
    endfunction

    // Sink: free-flowing, then a long hold-off, then a random stall pattern
    initial begin
        int len, pct;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        repeat (40) @(negedge i_clk) i_ready <= 1'b1;
        repeat (400) @(negedge i_clk) i_ready <= 1'b0;
        while (1) begin
            len = $urandom_range(60, 1);
            pct = $urandom_range(3) == 0 ? 0 : $urandom_range(90);
            repeat (len) @(negedge i_clk) i_ready <= ($urandom_range(99) >= pct);
        end
    end

    // Source and end of run
    initial begin
        t_in x;
        int  burst, gap, sent;
        board    = new();
        cycle    = 0;
        i_valid  = 1'b0;
        i_data   = '0;
        i_rst_n  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed edge sets
        send_edges(0, 0, 0, 0, 0, 0);
        send_edges(65535, 65535, 65535, 65535, 65535, 65535);
        send_edges(256, 256, 256, 256, 256, 256);
        send_edges(1, 1, 1, 1, 1, 1);
        // flat: four collinear points at 0, 1, 2, 3
        send_edges(256, 512, 768, 256, 512, 256);
        // flat: three points on one spot
        send_edges(0, 0, 300, 0, 300, 300);
        // impossible: one edge far too long
        send_edges(256, 256, 256, 256, 256, 65535);
        send_edges(65535, 0, 0, 0, 0, 0);
        send_edges(0, 0, 0, 0, 0, 65535);
        // 3-4-5 right triangle 1-2-3 with a fourth point that cannot exist
        send_edges(768, 1024, 0, 1280, 1024, 0);
        send_edges(65535, 65535, 65535, 65535, 65535, 1);
        send_edges(65535, 65535, 65535, 1, 1, 1);
        send_edges(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_edges(32768, 32768, 32768, 32768, 32768, 32768);

        // Random requests in bursts
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(30, 1);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                x = random_request();
                send_request(x);
                sent++;
            end
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                @(negedge i_clk) i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk) i_valid <= 1'b0;

        while (board.vol_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (board.n_err == 0 && board.vol_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
